// ===== rtl/stbs_pkg.sv =====
// Shared types and constants for the sorted table binary search block.
// Holds field widths, input mode codes and the search result record.
// No dependencies.
package stbs_pkg;

  localparam int unsigned IDX_W   = 10;  // entry_index and match_index width
  localparam int unsigned VALUE_W = 32;  // value field width
  localparam int unsigned LEN_W   = 11;  // list_length register width
  localparam int unsigned EXT_W   = 64;  // widest stored word

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } res_t;

endpackage

// ===== rtl/stbs_ram.sv =====
// Generic simple dual-port RAM: one write port and one read port with registered data.
// Used as the table store of the binary search block.
// No package dependencies.
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// Sorted table binary search.
// Channels: the input channel (in_valid/in_ready) takes items with in_mode,
// in_entry_index and in_value. A write item stores in_value at in_entry_index
// and gives no result. A search item bisects entries 0 to list_length-1
// and gives one result on the output channel (out_valid/out_ready): out_found and
// out_match_index. The list length is set through cfg_valid/cfg_ready/
// cfg_list_length, which is always ready and should be written while idle.
// Search: each bisection step is one table read and compare, bound by the single
// RAM read port, with at most floor(log2(depth)) + 1 steps and none for an empty
// list. The result then waits in ST_DONE until the output register is free and is
// loaded into it: out_valid rises and in_ready returns in the same cycle. Items are
// taken one at a time; in_ready is high only when no search is in progress.
// The output register holds a result until it is taken, so a new item can be
// accepted while the receiver stalls; a later search then waits until the
// register frees. Reset clears the control state and the list length, not the
// table: entries read before they are written return arbitrary data.
// Depends on stbs_pkg and stbs_ram.
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [stbs_pkg::IDX_W-1:0]       in_entry_index,
  input  logic signed [stbs_pkg::VALUE_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output logic [stbs_pkg::IDX_W-1:0]       out_match_index,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stbs_pkg::LEN_W-1:0]       cfg_list_length
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned BW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [stbs_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [BW-1:0]                lo_r, lo_nxt;
  logic [BW-1:0]                hi_r, hi_nxt;
  logic [AW-1:0]                mid_r, mid_nxt;
  logic [DATA_WIDTH-1:0]        key_r, key_nxt;
  stbs_pkg::res_t               res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  stbs_pkg::res_t               out_r, out_nxt;

  logic [stbs_pkg::EXT_W-1:0]   value_ext;
  logic [DATA_WIDTH-1:0]        in_word;
  logic [BW-1:0]                len_clamped;
  logic [BW:0]                  first_sum;
  logic [AW-1:0]                first_mid;
  logic                         write_ok;
  logic                         ram_we;
  logic [AW-1:0]                ram_raddr;
  logic [DATA_WIDTH-1:0]        ram_rdata;
  logic                         ent_eq;
  logic                         ent_gt;
  logic [BW-1:0]                lo_step;
  logic [BW-1:0]                hi_step;
  logic [BW:0]                  step_sum;
  logic [AW-1:0]                next_mid;
  logic                         out_free;

  // The value is taken as an unsigned 32-bit pattern and then read as a signed
  // word of the stored width, so narrower words truncate and wider ones zero-extend.
  assign value_ext = {{(stbs_pkg::EXT_W - stbs_pkg::VALUE_W){1'b0}}, in_value};
  assign in_word   = value_ext[DATA_WIDTH-1:0];

  assign len_clamped = (32'(len_r) > 32'(TABLE_DEPTH)) ? BW'(TABLE_DEPTH) : BW'(len_r);
  assign first_sum   = (BW + 1)'(len_clamped) - (BW + 1)'(1);
  assign first_mid   = AW'(first_sum >> 1);
  assign write_ok    = 32'(in_entry_index) < 32'(TABLE_DEPTH);

  // Shared compare unit: one table entry against the key per step.
  assign ent_eq   = ram_rdata == key_r;
  assign ent_gt   = $signed(ram_rdata) > $signed(key_r);
  assign lo_step  = ent_gt ? lo_r : BW'(mid_r) + BW'(1);
  assign hi_step  = ent_gt ? BW'(mid_r) : hi_r;
  assign step_sum = (BW + 1)'(lo_step) + (BW + 1)'(hi_step) - (BW + 1)'(1);
  assign next_mid = AW'(step_sum >> 1);

  assign out_free = !out_valid_r || out_ready;

  stbs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_entry_index)),
    .wdata (in_word),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_raddr     = mid_r;

    if (cfg_valid) begin
      len_nxt = cfg_list_length;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_mode == stbs_pkg::MODE_WRITE) begin
            ram_we = write_ok;
          end else begin
            key_nxt = in_word;
            lo_nxt  = '0;
            hi_nxt  = len_clamped;
            if (len_clamped == '0) begin
              res_nxt   = '0;
              state_nxt = ST_DONE;
            end else begin
              mid_nxt   = first_mid;
              ram_raddr = first_mid;
              state_nxt = ST_STEP;
            end
          end
        end
      end
      ST_STEP: begin
        if (ent_eq) begin
          res_nxt.found = 1'b1;
          res_nxt.index = stbs_pkg::IDX_W'(mid_r);
          state_nxt     = ST_DONE;
        end else begin
          lo_nxt = lo_step;
          hi_nxt = hi_step;
          if (lo_step < hi_step) begin
            mid_nxt   = next_mid;
            ram_raddr = next_mid;
          end else begin
            res_nxt   = '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign in_ready        = state_r == ST_IDLE;
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_found       = out_r.found;
  assign out_match_index = out_r.index;

  // A bisection step always works on a non-empty range.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> lo_r < hi_r)
    else $error("bisection step with an empty range");

  // A write transfer never starts a search.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == stbs_pkg::MODE_WRITE |=> state_r == ST_IDLE)
    else $error("write item left the idle state");

  // A miss reports index zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_index == '0)
    else $error("not-found result with a non-zero index");

  // A hit lies inside the searched list.
  a_hit_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> 32'(out_match_index) < 32'(len_r))
    else $error("match index beyond the list length");

endmodule

// ===== test/tb_sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sorted_table_binary_search: directed and random items,
// with an in-bench bisection predictor over its own copy of the table.
// Depends on stbs_pkg and the sorted_table_binary_search RTL.
module tb_sorted_table_binary_search;

  localparam int unsigned TABLE_DEPTH    = 1024;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned RANDOM_ITEMS   = 700;

  typedef struct packed {
    logic                         mode;
    logic [stbs_pkg::IDX_W-1:0]   index;
    logic [stbs_pkg::VALUE_W-1:0] value;
  } item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                in_mode = stbs_pkg::MODE_WRITE;
  logic [stbs_pkg::IDX_W-1:0]          in_entry_index = '0;
  logic signed [stbs_pkg::VALUE_W-1:0] in_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic                                out_found;
  logic [stbs_pkg::IDX_W-1:0]          out_match_index;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [stbs_pkg::LEN_W-1:0]          cfg_list_length = '0;

  // Stimulus side: items waiting for the driver and the generator's view of the table.
  item_t       item_queue[$];
  int          gen_words[TABLE_DEPTH];
  int unsigned queued_items = 0;

  // Prediction side, updated on each accepted transfer.
  logic signed [stbs_pkg::VALUE_W-1:0] stored_words[TABLE_DEPTH];
  logic [stbs_pkg::LEN_W-1:0]          live_length = '0;
  stbs_pkg::res_t                      search_answers[$];
  int unsigned                         taken_items = 0;
  int unsigned                         errors = 0;
  int unsigned                         idle_cycles = 0;

  // Handshake flags captured at the rising edge for the falling-edge drivers.
  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;
  bit cfg_taken = 1'b0;

  int unsigned in_gap = 0;
  bit          in_calm = 1'b0;
  int unsigned out_stall = 0;
  bit          out_calm = 1'b0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;

  sorted_table_binary_search DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_entry_index  (in_entry_index),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_match_index (out_match_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_list_length (cfg_list_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Bisection over the predicted table, first matching midpoint wins.
  function automatic stbs_pkg::res_t bisect(input logic signed [stbs_pkg::VALUE_W-1:0] key);
    int unsigned    lo;
    int unsigned    hi_ex;
    int unsigned    mid;
    stbs_pkg::res_t answer;
    bit             done;
    lo = 0;
    hi_ex = (32'(live_length) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(live_length);
    answer = '0;
    done = 1'b0;
    while (!done && lo < hi_ex) begin
      mid = (lo + hi_ex - 1) / 2;
      if (stored_words[mid] == key) begin
        answer.found = 1'b1;
        answer.index = stbs_pkg::IDX_W'(mid);
        done = 1'b1;
      end else if (stored_words[mid] > key) begin
        hi_ex = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return answer;
  endfunction

  // A word that rises with the entry index, starting from the most negative value.
  function automatic logic signed [stbs_pkg::VALUE_W-1:0] ramp_word(input int unsigned idx);
    longint w;
    w = longint'(idx) * 64'sd4096 - 64'sd2147483648;
    return w[stbs_pkg::VALUE_W-1:0];
  endfunction

  task automatic queue_write(input int unsigned idx,
                             input logic signed [stbs_pkg::VALUE_W-1:0] val);
    item_queue.push_back('{stbs_pkg::MODE_WRITE, stbs_pkg::IDX_W'(idx), val});
    gen_words[idx] = val;
    queued_items++;
  endtask

  task automatic queue_search(input logic signed [stbs_pkg::VALUE_W-1:0] key);
    item_queue.push_back('{stbs_pkg::MODE_SEARCH,
                           stbs_pkg::IDX_W'($urandom_range(TABLE_DEPTH - 1)), key});
    queued_items++;
  endtask

  // Writes a rising word into each entry that a search over count entries visits on
  // its way to target, then searches for that entry's word or for one just above it.
  task automatic queue_path(input int unsigned count, input int unsigned target,
                            input bit above);
    int unsigned lo;
    int unsigned hi_ex;
    int unsigned mid;
    bit          hit;
    lo = 0;
    hi_ex = count;
    hit = 1'b0;
    while (!hit && lo < hi_ex) begin
      mid = (lo + hi_ex - 1) / 2;
      queue_write(mid, ramp_word(mid));
      if (mid == target && !above) hit = 1'b1;
      else if (mid > target) hi_ex = mid;
      else lo = mid + 1;
    end
    queue_search(above ? ramp_word(target) + 32'sd1 : ramp_word(target));
  endtask

  // Writes entries 0 to count-1, ascending with some repeats, or in no order at all.
  task automatic fill_table(input int unsigned count, input bit ordered);
    longint span;
    longint cur;
    longint rnd;
    span = 64'sd4294967296 / (longint'(count) + 1);
    rnd = longint'($urandom);
    cur = rnd % span - 64'sd2147483648;
    for (int unsigned i = 0; i < count; i++) begin
      if (!ordered) begin
        rnd = longint'($urandom);
        cur = rnd - 64'sd2147483648;
      end else if (i > 0 && $urandom_range(3) != 0) begin
        rnd = longint'($urandom);
        cur = cur + rnd % span;
      end
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      queue_write(i, cur[stbs_pkg::VALUE_W-1:0]);
    end
  endtask

  // The sender holds back until everything queued is taken and every answer is in.
  task automatic wait_quiet();
    while (taken_items != queued_items || search_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_length(input int unsigned len);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_list_length <= stbs_pkg::LEN_W'(len);
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // Input driver.
  always @(negedge clk) begin
    item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (item_queue.size() > 0) begin
        nxt = item_queue.pop_front();
        in_valid <= 1'b1;
        in_mode <= nxt.mode;
        in_entry_index <= nxt.index;
        in_value <= nxt.value;
        if ($urandom_range(49) == 0) in_calm = !in_calm;
        in_gap = (in_calm || $urandom_range(1) == 0) ? 0 : next_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver, with its own count for the long hold-off.
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      out_stall = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else if (!out_calm && $urandom_range(3) == 0) begin
      out_stall = next_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    if ($urandom_range(99) == 0) out_calm = !out_calm;
  end

  // Monitor: predicts on each accepted item and checks each result transfer.
  always @(posedge clk) begin
    stbs_pkg::res_t want;
    in_taken  = in_valid && in_ready;
    out_taken = out_valid && out_ready;
    cfg_taken = cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_taken) live_length = cfg_list_length;
      if (in_taken) begin
        taken_items++;
        if (in_mode == stbs_pkg::MODE_WRITE) stored_words[in_entry_index] = in_value;
        else search_answers.push_back(bisect(in_value));
      end
      if (out_taken) begin
        if (search_answers.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: found %0b, index %0d",
                   $time, out_found, out_match_index);
        end else begin
          want = search_answers.pop_front();
          if (out_found !== want.found) begin
            errors++;
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, out_found);
          end
          if (out_match_index !== want.index) begin
            errors++;
            $display("%0t: match_index mismatch: expected %0d, actual %0d",
                     $time, want.index, out_match_index);
          end
        end
      end
      if (in_taken || out_taken || cfg_taken) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("sorted_table_binary_search regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_items;
    int unsigned len;
    int unsigned live;
    int unsigned count;
    int unsigned r;
    int unsigned j;
    int unsigned mark;
    logic signed [stbs_pkg::VALUE_W-1:0] key;

    random_items = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Empty list: nothing can match.
    program_length(0);
    queue_search(0);
    item_queue.push_back('{stbs_pkg::MODE_SEARCH, stbs_pkg::IDX_W'(TABLE_DEPTH - 1),
                           32'sh8000_0000});
    queued_items++;

    // A short table with both extremes and a run of duplicates.
    queue_write(0, 32'sh8000_0000);
    queue_write(1, -5);
    queue_write(2, 0);
    queue_write(3, 0);
    queue_write(4, 0);
    queue_write(5, 7);
    queue_write(6, 100);
    queue_write(7, 32'sh7fff_ffff);
    queue_write(TABLE_DEPTH - 1, -1);
    program_length(8);
    queue_search(32'sh8000_0000);
    queue_search(32'sh7fff_ffff);
    queue_search(0);
    queue_search(-5);
    queue_search(100);
    queue_search(-6);
    queue_search(32'sh7fff_fffe);
    queue_search(8);
    program_length(1);
    queue_search(32'sh8000_0000);
    queue_search(1);

    for (int unsigned phase = 0; phase < 5 || random_items < RANDOM_ITEMS; phase++) begin
      if (phase == 1) len = 2047;
      else if (phase == 3) len = TABLE_DEPTH;
      else if (phase == 6) len = 0;
      else begin
        r = $urandom_range(9);
        if (r < 7) len = $urandom_range(40, 1);
        else if (r < 9) len = $urandom_range(200, 41);
        else len = $urandom_range(600, 201);
      end
      live = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
      program_length(len);
      if (phase == 2) hold_asked++;
      mark = queued_items;
      if (live > 600) begin
        // A list as deep as the table: only the entries on each search's path are written.
        count = $urandom_range(12, 6);
        for (int unsigned n = 0; n < count; n++) begin
          queue_path(live, $urandom_range(live - 1), 1'($urandom_range(1)));
        end
      end else begin
        fill_table(live, !(phase == 4 || $urandom_range(7) == 0));
        count = $urandom_range(40, 10);
        for (int unsigned n = 0; n < count; n++) begin
          r = $urandom_range(31);
          if (r == 0 && live < TABLE_DEPTH) begin
            queue_write($urandom_range(TABLE_DEPTH - 1, live), $urandom);
          end else if (r == 1 && live > 0) begin
            // Overwrites inside the list, which may break the ordering.
            queue_write($urandom_range(live - 1), $urandom);
          end else begin
            r = $urandom_range(9);
            if (live == 0 || r >= 7) begin
              key = $urandom;
            end else begin
              j = $urandom_range(live - 1);
              key = gen_words[j];
              if (r == 5) key = key + 1;
              else if (r == 6) key = key - 1;
            end
            queue_search(key);
          end
        end
      end
      random_items += queued_items - mark;
    end

    while (taken_items != queued_items || search_answers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("sorted_table_binary_search regression: pass");
    end else begin
      $display("sorted_table_binary_search regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/sorted_table_binary_search.sv
test/tb_sorted_table_binary_search.sv
